/* design/rga_pkg.sv */
// shared constants and types for the fraction arithmetic block
`timescale 1ns / 1ps

package rga_pkg;

  // default operand width
  localparam int OPERAND_WIDTH_DEF = 16;

  // result field widths
  localparam int RESULT_NUM_W = 32;
  localparam int RESULT_DEN_W = 31;

  // operation codes
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ADD = 2'd0;
  localparam cmd_t CMD_SUB = 2'd1;
  localparam cmd_t CMD_MUL = 2'd2;
  localparam cmd_t CMD_DIV = 2'd3;

  // status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_DIV_ZERO = 1'b1;

endpackage

/* design/rga_if.sv */
// operand and result channel interfaces
`timescale 1ns / 1ps

interface rga_in_if #(
  parameter int OPERAND_WIDTH = rga_pkg::OPERAND_WIDTH_DEF
);
  import rga_pkg::*;

  logic                            valid;
  logic                            ready;
  cmd_t                            command;
  logic signed [OPERAND_WIDTH-1:0] left_num;
  logic        [OPERAND_WIDTH-2:0] left_den;
  logic signed [OPERAND_WIDTH-1:0] right_num;
  logic        [OPERAND_WIDTH-2:0] right_den;

  modport source (
    output valid, command, left_num, left_den, right_num, right_den,
    input  ready
  );
  modport sink (
    input  valid, command, left_num, left_den, right_num, right_den,
    output ready
  );
endinterface

interface rga_out_if;
  import rga_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [RESULT_NUM_W-1:0] result_num;
  logic        [RESULT_DEN_W-1:0] result_den;
  logic                           status;

  modport source (
    output valid, result_num, result_den, status,
    input  ready
  );
  modport sink (
    input  valid, result_num, result_den, status,
    output ready
  );
endinterface

/* design/rational_arith_gcd_reduce_top.sv */
// Fraction add/sub/mul/div with gcd reduction on one shared iterative datapath.
// Steps: products on one shared multiplier (S_MUL0, S_MUL1, S_MUL2), a combine step
// (S_COMB), a binary gcd, then two restoring divisions by the gcd over PW bits
// (PW = 2*OPERAND_WIDTH); a zero numerator or a zero denominator goes straight
// from the combine step to the result.
// One word at a time: the next operand word is taken after the result is taken.
// Synchronous active-high reset returns the sequencer to idle with no result.
`timescale 1ns / 1ps

module rational_arith_gcd_reduce_top #(
  parameter int OPERAND_WIDTH = rga_pkg::OPERAND_WIDTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  rga_in_if.sink operands,
  rga_out_if.source result
);
  import rga_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = $clog2(PW + 1);
  localparam int CW = $clog2(PW);
  localparam int XW = (PW > RESULT_NUM_W) ? PW : RESULT_NUM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_COMB,
    S_GSHIFT, S_GAEVEN, S_GLOOP, S_DIVN, S_DIVD, S_OUT
  } state_t;

  state_t state;

  // captured operands as sign and magnitude
  cmd_t         cmd;
  logic [W-1:0] ln;
  logic [W-1:0] rn;
  logic [W-2:0] ld;
  logic [W-2:0] rd;
  logic         ln_neg;
  logic         rn_neg;

  // products, reduced values and gcd registers
  logic [PW-1:0] t1;
  logic [PW-1:0] t2;
  logic [PW-1:0] num_mag;
  logic [PW-1:0] den_mag;
  logic          neg;
  logic [PW-1:0] ga;
  logic [PW-1:0] gb;
  logic [SW-1:0] shift;
  logic [PW-1:0] g;

  // divider registers
  logic [PW-1:0] dq;
  logic [PW-1:0] dr;
  logic [CW-1:0] cnt;

  // result registers
  logic signed [RESULT_NUM_W-1:0] res_num;
  logic        [RESULT_DEN_W-1:0] res_den;
  logic                           res_status;

  // operand magnitudes at the port
  logic         ln_in_neg;
  logic         rn_in_neg;
  logic [W-1:0] ln_in_mag;
  logic [W-1:0] rn_in_mag;

  assign ln_in_neg = operands.left_num[W-1];
  assign rn_in_neg = operands.right_num[W-1];
  assign ln_in_mag = ln_in_neg ? W'(~operands.left_num + 1'b1) : W'(operands.left_num);
  assign rn_in_mag = rn_in_neg ? W'(~operands.right_num + 1'b1) : W'(operands.right_num);

  // shared multiplier operand select
  logic [W-1:0]  ma;
  logic [W-1:0]  mb;
  logic [PW-1:0] prod;

  always_comb begin
    case (state)
      S_MUL0: begin
        ma = ln;
        mb = (cmd == CMD_MUL) ? rn : {1'b0, rd};
      end
      S_MUL1: begin
        ma = rn;
        mb = {1'b0, ld};
      end
      default: begin
        ma = {1'b0, ld};
        mb = (cmd == CMD_DIV) ? rn : {1'b0, rd};
      end
    endcase
  end

  assign prod = PW'(ma) * PW'(mb);

  // combine cross products into a signed numerator
  logic [PW-1:0] comb_num;
  logic          comb_neg;
  logic          s2;

  always_comb begin
    s2 = (cmd == CMD_SUB) ? !rn_neg : rn_neg;
    if (cmd == CMD_ADD || cmd == CMD_SUB) begin
      if (ln_neg == s2) begin
        comb_num = t1 + t2;
        comb_neg = ln_neg;
      end else if (t1 >= t2) begin
        comb_num = t1 - t2;
        comb_neg = ln_neg;
      end else begin
        comb_num = t2 - t1;
        comb_neg = s2;
      end
    end else begin
      comb_num = t1;
      comb_neg = ln_neg ^ rn_neg;
    end
  end

  // one gcd subtract step
  logic          a_gt_b;
  logic [PW-1:0] gdiff;

  assign a_gt_b = ga > gb;
  assign gdiff  = a_gt_b ? (ga - gb) : (gb - ga);

  // one restoring division step
  logic [PW:0]   trial;
  logic          div_bit;
  logic [PW-1:0] dr_next;
  logic [PW-1:0] dq_next;

  assign trial   = {dr, dq[PW-1]};
  assign div_bit = trial >= {1'b0, g};
  assign dr_next = div_bit ? PW'(trial - {1'b0, g}) : trial[PW-1:0];
  assign dq_next = {dq[PW-2:0], div_bit};

  // final sign and width fitting
  logic [XW-1:0] q_ext;
  logic [XW-1:0] q_signed;
  logic [XW-1:0] d_ext;

  assign q_ext    = XW'(num_mag);
  assign q_signed = neg ? (~q_ext + 1'b1) : q_ext;
  assign d_ext    = XW'(dq_next);

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (operands.valid) begin
            cmd    <= operands.command;
            ln     <= ln_in_mag;
            rn     <= rn_in_mag;
            ln_neg <= ln_in_neg;
            rn_neg <= rn_in_neg;
            ld     <= operands.left_den;
            rd     <= operands.right_den;
            state  <= S_MUL0;
          end
        end
        S_MUL0: begin
          t1    <= prod;
          state <= S_MUL1;
        end
        S_MUL1: begin
          t2    <= prod;
          state <= S_MUL2;
        end
        S_MUL2: begin
          den_mag <= prod;
          state   <= S_COMB;
        end
        S_COMB: begin
          num_mag <= comb_num;
          neg     <= comb_neg;
          ga      <= comb_num;
          gb      <= den_mag;
          shift   <= '0;
          if (den_mag == '0) begin
            res_num    <= '0;
            res_den    <= RESULT_DEN_W'(1);
            res_status <= STATUS_DIV_ZERO;
            state      <= S_OUT;
          end else if (comb_num == '0) begin
            res_num    <= '0;
            res_den    <= RESULT_DEN_W'(1);
            res_status <= STATUS_OK;
            state      <= S_OUT;
          end else begin
            state <= S_GSHIFT;
          end
        end
        S_GSHIFT: begin
          // strip common factors of two
          if (!ga[0] && !gb[0]) begin
            ga    <= ga >> 1;
            gb    <= gb >> 1;
            shift <= shift + 1'b1;
          end else begin
            state <= S_GAEVEN;
          end
        end
        S_GAEVEN: begin
          if (!ga[0]) begin
            ga <= ga >> 1;
          end else begin
            state <= S_GLOOP;
          end
        end
        S_GLOOP: begin
          if (gb == '0) begin
            g     <= ga << shift;
            dq    <= num_mag;
            dr    <= '0;
            cnt   <= '0;
            state <= S_DIVN;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else begin
            if (a_gt_b) begin
              ga <= gb;
            end
            gb <= gdiff;
          end
        end
        S_DIVN: begin
          if (cnt == CW'(PW - 1)) begin
            num_mag <= dq_next;
            dq      <= den_mag;
            dr      <= '0;
            cnt     <= '0;
            state   <= S_DIVD;
          end else begin
            cnt <= cnt + 1'b1;
            dq  <= dq_next;
            dr  <= dr_next;
          end
        end
        S_DIVD: begin
          cnt <= cnt + 1'b1;
          dq  <= dq_next;
          dr  <= dr_next;
          if (cnt == CW'(PW - 1)) begin
            res_num    <= q_signed[RESULT_NUM_W-1:0];
            res_den    <= d_ext[RESULT_DEN_W-1:0];
            res_status <= STATUS_OK;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (result.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // channel outputs
  assign operands.ready    = (state == S_IDLE);
  assign result.valid      = (state == S_OUT);
  assign result.result_num = res_num;
  assign result.result_den = res_den;
  assign result.status     = res_status;

`ifndef SYNTH
  // never taking a word while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    operands.ready |-> !result.valid)
    else $error("operand ready while result pending");

  // an accepted word closes the input side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (operands.valid && operands.ready) |=> !operands.ready)
    else $error("still ready after accept");

  // a good result never has a zero denominator
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == STATUS_OK) |-> result.result_den != '0)
    else $error("zero denominator in ok result");

  // error result is always 0/1
  a_err_zero_one: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == STATUS_DIV_ZERO) |->
      (result.result_num == '0 && result.result_den == RESULT_DEN_W'(1)))
    else $error("error result not 0/1");

  // gcd divisor is nonzero while dividing
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVN || state == S_DIVD) |-> g != '0)
    else $error("zero divisor in division");
`endif

endmodule

/* bench/fraction_checker.sv */
// checker for the fraction arithmetic block: predicts each reduced result and compares it
`timescale 1ns / 1ps

module fraction_checker #(
  parameter int OPERAND_WIDTH = rga_pkg::OPERAND_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  rga_in_if    operands,
  rga_out_if   result,
  output int   errors,
  output int   pending,
  output int   checked,
  output int   div_zero_seen
);
  import rga_pkg::*;

  localparam int W = OPERAND_WIDTH;

  typedef struct packed {
    logic signed [RESULT_NUM_W-1:0] num;
    logic        [RESULT_DEN_W-1:0] den;
    logic                           status;
  } fraction_t;

  // results owed by the block, oldest first
  fraction_t awaited_fractions[$];

  // exact fraction arithmetic followed by reduction to lowest terms
  function automatic fraction_t reduce_fraction(cmd_t cmd, logic signed [W-1:0] ln,
                                                logic [W-2:0] ld, logic signed [W-1:0] rn,
                                                logic [W-2:0] rd);
    longint a, b, c, d, num, den, m, n, t;
    fraction_t f;
    a = ln;
    b = ld;
    c = rn;
    d = rd;
    case (cmd)
      CMD_ADD: begin
        num = a * d + c * b;
        den = b * d;
      end
      CMD_SUB: begin
        num = a * d - c * b;
        den = b * d;
      end
      CMD_MUL: begin
        num = a * c;
        den = b * d;
      end
      default: begin
        // divide: the sign of the right numerator moves over to the numerator
        num = a * d;
        den = b * c;
        if (den < 0) begin
          num = -num;
          den = -den;
        end
      end
    endcase
    f.num = '0;
    f.den = RESULT_DEN_W'(1);
    f.status = STATUS_OK;
    if (den == 0) begin
      f.status = STATUS_DIV_ZERO;
    end else if (num != 0) begin
      // euclid on the magnitudes
      m = (num < 0) ? -num : num;
      n = den;
      while (n != 0) begin
        t = m % n;
        m = n;
        n = t;
      end
      num = num / m;
      den = den / m;
      f.num = RESULT_NUM_W'(num);
      f.den = RESULT_DEN_W'(den);
    end
    return f;
  endfunction

  // result side is handled before the operand side so a word is never matched to itself
  always @(posedge clk) begin
    fraction_t want;
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (awaited_fractions.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected: got %0d/%0d status %0b", $time,
                   result.result_num, result.result_den, result.status);
        end else begin
          want = awaited_fractions.pop_front();
          checked++;
          if (want.status == STATUS_DIV_ZERO)
            div_zero_seen++;
          if (result.result_num !== want.num) begin
            errors++;
            $display("%0t: numerator mismatch: expected %0d, got %0d", $time, want.num,
                     result.result_num);
          end
          if (result.result_den !== want.den) begin
            errors++;
            $display("%0t: denominator mismatch: expected %0d, got %0d", $time, want.den,
                     result.result_den);
          end
          if (result.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0b, got %0b", $time, want.status,
                     result.status);
          end
        end
      end
      if (operands.valid && operands.ready)
        awaited_fractions.push_back(reduce_fraction(operands.command, operands.left_num,
                                                    operands.left_den, operands.right_num,
                                                    operands.right_den));
    end
    pending = awaited_fractions.size();
  end

endmodule

/* bench/rational_arith_gcd_reduce_top_tb.sv */
// testbench top for the fraction arithmetic block: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module rational_arith_gcd_reduce_top_tb;
  import rga_pkg::*;

  localparam int W = OPERAND_WIDTH_DEF;
  localparam int DW = W - 1;
  localparam int RANDOM_WORDS = 450;

  logic clk;
  logic rst;
  bit   no_idle;
  int   words_sent;
  int   errors, pending, checked, div_zero_seen;

  rga_in_if #(.OPERAND_WIDTH(W)) operands ();
  rga_out_if result ();

  rational_arith_gcd_reduce_top #(.OPERAND_WIDTH(W)) DUT (
    .clk      (clk),
    .rst      (rst),
    .operands (operands),
    .result   (result)
  );

  fraction_checker #(.OPERAND_WIDTH(W)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .operands      (operands),
    .result        (result),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked),
    .div_zero_seen (div_zero_seen)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // numerators: full range, small values, extremes, zero and values with shared factors
  function automatic logic signed [W-1:0] rand_num();
    logic signed [W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = W'($urandom);
      4, 5: begin
        v = W'($urandom_range(0, 64));
        v = v - W'(32);
      end
      6: v = $urandom_range(0, 1) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      7: v = '0;
      default: begin
        v = W'($urandom_range(1, 255) << $urandom_range(0, 7));
        if ($urandom_range(0, 1) != 0)
          v = -v;
      end
    endcase
    return v;
  endfunction

  // denominators: mostly valid, with a few zeros to hit the error path
  function automatic logic [W-2:0] rand_den();
    logic [W-2:0] v;
    case ($urandom_range(0, 19))
      0: v = '0;
      1: v = DW'(1);
      2: v = '1;
      3, 4, 5, 6, 7: v = DW'($urandom_range(1, 64));
      8, 9, 10, 11: v = DW'($urandom_range(1, 127) << $urandom_range(0, 7));
      default: v = DW'($urandom);
    endcase
    return v;
  endfunction

  // present one operand word and hold it until the block takes it
  task automatic send_word(cmd_t cmd, logic signed [W-1:0] ln, logic [W-2:0] ld,
                           logic signed [W-1:0] rn, logic [W-2:0] rd);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      operands.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operands.valid     <= 1'b1;
    operands.command   <= cmd;
    operands.left_num  <= ln;
    operands.left_den  <= ld;
    operands.right_num <= rn;
    operands.right_den <= rd;
    do @(posedge clk); while (!operands.ready);
    words_sent++;
  endtask

  // result side: random stall before each word
  initial begin
    int stall;
    result.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
    end
  end

  // stimulus and verdict
  initial begin
    cmd_t cmd;
    int directed;
    rst                <= 1'b1;
    operands.valid     <= 1'b0;
    operands.command   <= CMD_ADD;
    operands.left_num  <= '0;
    operands.left_den  <= DW'(1);
    operands.right_num <= '0;
    operands.right_den <= DW'(1);
    no_idle = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, zero numerators, zero fractions and zero denominators
    send_word(CMD_ADD, 0, 1, 0, 1);
    send_word(CMD_ADD, 32767, 32767, 32767, 32767);
    send_word(CMD_ADD, -32768, 1, -32768, 1);
    send_word(CMD_ADD, -3, 4, 1, 4);
    send_word(CMD_ADD, 3, 0, 4, 5);
    send_word(CMD_SUB, 5, 7, 5, 7);
    send_word(CMD_SUB, -32768, 32767, 32767, 1);
    send_word(CMD_SUB, 1, 32767, -1, 32766);
    send_word(CMD_SUB, 0, 0, 0, 0);
    send_word(CMD_MUL, -32768, 1, -32768, 1);
    send_word(CMD_MUL, 32767, 32767, -32768, 32767);
    send_word(CMD_MUL, 0, 3, -5, 9);
    send_word(CMD_MUL, 6, 4, 10, 15);
    send_word(CMD_MUL, 3, 5, 4, 0);
    send_word(CMD_DIV, 3, 4, 0, 5);
    send_word(CMD_DIV, 0, 4, 0, 5);
    send_word(CMD_DIV, -1, 32767, -32768, 1);
    send_word(CMD_DIV, 32767, 1, 1, 32767);
    send_word(CMD_DIV, -32768, 32767, 1, 32767);
    send_word(CMD_DIV, 4, 9, -2, 3);
    send_word(CMD_DIV, 0, 0, 7, 1);
    send_word(CMD_DIV, -32768, 1, -1, 1);
    directed = words_sent;

    // random words, every so often a stretch with no idling on either side
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0)
        no_idle = ($urandom_range(0, 2) == 0);
      cmd = cmd_t'($urandom_range(0, 3));
      send_word(cmd, rand_num(), rand_den(), rand_num(), rand_den());
    end
    operands.valid <= 1'b0;
    no_idle = 1'b0;

    // drain, then allow for a full worst-case latency
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("run covered %0d operand words (%0d directed) and %0d checked results",
             words_sent, directed, checked);
    $display("%0d results were division errors; idle gaps of 0 to 4 cycles on both sides",
             div_zero_seen);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
design/rga_pkg.sv
design/rga_if.sv
design/rational_arith_gcd_reduce_top.sv
bench/fraction_checker.sv
bench/rational_arith_gcd_reduce_top_tb.sv
